// File: design/matrix_vector_transform_defines.svh
// Assertion macros shared by the transform unit.
// Both forms take a label, the clock, the active-low reset, an antecedent
// and a consequent. The first checks in the same cycle, the second in the
// cycle after.
`ifndef MATRIX_VECTOR_TRANSFORM_DEFINES_SVH
`define MATRIX_VECTOR_TRANSFORM_DEFINES_SVH

`ifndef SYNTHESIS
`define MVT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mvt: assertion failed");
`define MVT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mvt: assertion failed");
`else
`define MVT_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define MVT_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

// File: design/mvt_pkg.sv
`default_nettype none

package mvt_pkg;

  // Number format and matrix geometry.
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int VEC_N     = 4;
  localparam int MAT_N     = VEC_N * VEC_N;
  localparam int IDX_W     = $clog2(MAT_N);
  localparam int PROD_W    = 2 * DATA_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int ACC_W     = PROD_W + 2;

  // Request modes.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_XFORM = 1'b1;

  // One in the fixed-point format.
  localparam logic [DATA_W-1:0] FX_ONE = DATA_W'(1) << FRAC_BITS;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef word_t vec_t   [VEC_N];
  typedef word_t mat_t   [MAT_N];
  typedef prod_t prods_t [MAT_N];

  // Reset value of one matrix element: one on the diagonal, zero elsewhere.
  // Row and column are the low and high halves of the position.
  function automatic word_t ident_elem(input logic [IDX_W-1:0] idx);
    logic diag;
    diag = (idx[IDX_W/2-1:0] == idx[IDX_W-1:IDX_W/2]);
    return diag ? word_t'(FX_ONE) : word_t'('0);
  endfunction

endpackage

`default_nettype wire

// File: design/mvt_in_if.sv
`default_nettype none

// Request channel: a matrix element load or a vector to transform.
interface mvt_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic [mvt_pkg::IDX_W-1:0]           elem_index;
  logic signed [mvt_pkg::DATA_W-1:0]   elem_value;
  logic signed [mvt_pkg::DATA_W-1:0]   vec_x;
  logic signed [mvt_pkg::DATA_W-1:0]   vec_y;
  logic signed [mvt_pkg::DATA_W-1:0]   vec_z;
  logic signed [mvt_pkg::DATA_W-1:0]   vec_w;

  modport source (output valid, mode, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
                  input ready);
  modport sink (input valid, mode, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
                output ready);
endinterface

`default_nettype wire

// File: design/mvt_out_if.sv
`default_nettype none

// Result channel: the transformed vector and its saturation flag.
interface mvt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mvt_pkg::DATA_W-1:0]   out_x;
  logic signed [mvt_pkg::DATA_W-1:0]   out_y;
  logic signed [mvt_pkg::DATA_W-1:0]   out_z;
  logic signed [mvt_pkg::DATA_W-1:0]   out_w;
  logic                                overflow;

  modport source (output valid, out_x, out_y, out_z, out_w, overflow, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, overflow, output ready);
endinterface

`default_nettype wire

// File: design/mvt_mac.sv
`default_nettype none

// Product stage: all sixteen element-by-component products in one register.
module mvt_mac (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire mvt_pkg::mat_t   mat_i,
  input  wire mvt_pkg::vec_t   vec_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output mvt_pkg::prods_t      prod_o
);

  logic            valid_q;
  mvt_pkg::prods_t prod_q;
  mvt_pkg::prods_t prod_d;

  // The stage takes a new vector when empty or when its content moves on.
  assign ready_o = !valid_q || ready_i;

  // Element (row, column) is multiplied by vector component 'column'.
  always_comb begin
    for (int i = 0; i < mvt_pkg::MAT_N; i++) begin
      prod_d[i] = mvt_pkg::prod_t'(mat_i[i]) * mvt_pkg::prod_t'(vec_i[i / mvt_pkg::VEC_N]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

`default_nettype wire

// File: design/mvt_reduce.sv
`default_nettype none

// Row reduction: pairwise sums, then the row sum, the fraction shift and
// saturation into the output register.
module mvt_reduce (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire mvt_pkg::prods_t   prod_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output mvt_pkg::vec_t          res_o,
  output logic                   ovf_o
);

  // The shifted sum fits a word when every bit from its top down to the word's
  // sign bit is the same.
  localparam int HI_W = mvt_pkg::ACC_W - mvt_pkg::DATA_W + 1;

  logic            pv_q;
  logic            ov_q;
  logic            pair_adv;
  logic            out_adv;
  mvt_pkg::pair_t  pair_q [mvt_pkg::VEC_N][2];
  mvt_pkg::pair_t  pair_d [mvt_pkg::VEC_N][2];
  mvt_pkg::vec_t   res_q;
  mvt_pkg::vec_t   res_d;
  logic            ovf_q;
  logic            ovf_d;

  // Handshake between the two internal stages and the result port.
  assign out_adv  = !ov_q || ready_i;
  assign pair_adv = !pv_q || out_adv;
  assign ready_o  = pair_adv;

  // Columns 0+1 and 2+3 of every row.
  always_comb begin
    for (int r = 0; r < mvt_pkg::VEC_N; r++) begin
      for (int k = 0; k < 2; k++) begin
        pair_d[r][k] = mvt_pkg::pair_t'(prod_i[r + mvt_pkg::VEC_N * (2 * k)])
                     + mvt_pkg::pair_t'(prod_i[r + mvt_pkg::VEC_N * (2 * k + 1)]);
      end
    end
  end

  // Full row sum, arithmetic shift (floor) and clamp to the word range.
  always_comb begin
    mvt_pkg::acc_t        sum;
    mvt_pkg::acc_t        sh;
    logic [HI_W-1:0]      hi;
    ovf_d = 1'b0;
    for (int r = 0; r < mvt_pkg::VEC_N; r++) begin
      sum = mvt_pkg::acc_t'(pair_q[r][0]) + mvt_pkg::acc_t'(pair_q[r][1]);
      sh  = sum >>> mvt_pkg::FRAC_BITS;
      hi  = sh[mvt_pkg::ACC_W-1 -: HI_W];
      if ((&hi) || !(|hi)) begin
        res_d[r] = sh[mvt_pkg::DATA_W-1:0];
      end else begin
        ovf_d    = 1'b1;
        res_d[r] = sh[mvt_pkg::ACC_W-1] ? {1'b1, {(mvt_pkg::DATA_W-1){1'b0}}}
                                        : {1'b0, {(mvt_pkg::DATA_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (pair_adv) begin
        pv_q <= valid_i;
      end
      if (out_adv) begin
        ov_q <= pv_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_adv && valid_i) begin
      pair_q <= pair_d;
    end
    if (out_adv && pv_q) begin
      res_q <= res_d;
      ovf_q <= ovf_d;
    end
  end

  assign valid_o = ov_q;
  assign res_o   = res_q;
  assign ovf_o   = ovf_q;

endmodule

`default_nettype wire

// File: design/matrix_vector_transform.sv
`default_nettype none

// 4x4 homogeneous transform unit in signed Q16.16. The matrix is held in
// column-major order (element row + 4*column) and comes out of reset as the
// identity. A load request writes one element and returns nothing; a
// transform request presents M*v from the output register, with every
// row floored after the fraction shift and clamped to 32 bits, overflow being
// set if any row was clamped. One request is taken in every cycle while the
// result side keeps up; the figure is set by the sixteen parallel 32x32
// multipliers of the product stage. The pipeline is matrix capture, products,
// pairwise sums and row sum with saturation. A transform uses the matrix as it
// stood when it was accepted, so a load takes effect from the next request on.
// Back-pressure on the result side stalls the pipeline without loss.
`include "matrix_vector_transform_defines.svh"

module matrix_vector_transform (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mvt_in_if.sink     in_i,
  mvt_out_if.source  out_o
);

  mvt_pkg::mat_t   mat_q;
  mvt_pkg::mat_t   s1_mat_q;
  mvt_pkg::vec_t   s1_vec_q;
  mvt_pkg::vec_t   res;
  mvt_pkg::prods_t prod;
  logic            s1_valid_q;
  logic            mac_ready;
  logic            mac_valid;
  logic            red_ready;
  logic            in_ready;
  logic            in_acc;
  logic            load_acc;
  logic            xform_acc;

  // Request decode.
  assign in_ready  = !s1_valid_q || mac_ready;
  assign in_i.ready = in_ready;
  assign in_acc    = in_i.valid && in_ready;
  assign load_acc  = in_acc && (in_i.mode == mvt_pkg::MODE_LOAD);
  assign xform_acc = in_acc && (in_i.mode == mvt_pkg::MODE_XFORM);

  // Matrix store, identity after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mvt_pkg::MAT_N; i++) begin
        mat_q[i] <= mvt_pkg::ident_elem(i[mvt_pkg::IDX_W-1:0]);
      end
    end else if (load_acc) begin
      mat_q[in_i.elem_index] <= in_i.elem_value;
    end
  end

  // Capture stage: vector plus a copy of the matrix as it stands now.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= xform_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (xform_acc) begin
      s1_mat_q    <= mat_q;
      s1_vec_q[0] <= in_i.vec_x;
      s1_vec_q[1] <= in_i.vec_y;
      s1_vec_q[2] <= in_i.vec_z;
      s1_vec_q[3] <= in_i.vec_w;
    end
  end

  mvt_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .ready_o (mac_ready),
    .mat_i   (s1_mat_q),
    .vec_i   (s1_vec_q),
    .valid_o (mac_valid),
    .ready_i (red_ready),
    .prod_o  (prod)
  );

  mvt_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mac_valid),
    .ready_o (red_ready),
    .prod_i  (prod),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res),
    .ovf_o   (out_o.overflow)
  );

  // Result fields.
  assign out_o.out_x = res[0];
  assign out_o.out_y = res[1];
  assign out_o.out_z = res[2];
  assign out_o.out_w = res[3];

  // A loaded element is in the store in the cycle after it is accepted.
  `MVT_ASSERT_NXT(a_load_written, clk_i, rst_ni, load_acc, mat_q[$past(in_i.elem_index)] == $past(in_i.elem_value))
  // A load never occupies the capture stage.
  `MVT_ASSERT_NXT(a_load_no_slot, clk_i, rst_ni, load_acc, s1_valid_q == $past(s1_valid_q && !mac_ready))
  // A captured vector handed to the product stage shows up there.
  `MVT_ASSERT_NXT(a_mac_handoff, clk_i, rst_ni, s1_valid_q && mac_ready, mac_valid)

endmodule

`default_nettype wire

// File: sim/mvt_vertex_sb_pkg.sv
`timescale 1ns / 100ps

package mvt_vertex_sb_pkg;
  import mvt_pkg::*;

  // One request as it crosses the input handshake.
  typedef struct {
    logic             mode;
    logic [IDX_W-1:0] index;
    word_t            value;
    word_t            vx;
    word_t            vy;
    word_t            vz;
    word_t            vw;
  } xform_req_t;

  // One transformed vertex as it leaves the block.
  typedef struct {
    word_t x;
    word_t y;
    word_t z;
    word_t w;
    logic  ovf;
  } vertex_t;

  // Bounds of a row after the fraction shift, at accumulator width.
  localparam acc_t ROW_MAX = (acc_t'(1) <<< (DATA_W - 1)) - acc_t'(1);
  localparam acc_t ROW_MIN = -(acc_t'(1) <<< (DATA_W - 1));

  class vertex_scoreboard;
    word_t       coeff[MAT_N];
    vertex_t     expected_vertices[$];
    int unsigned mismatches;

    // The matrix comes out of reset as the identity.
    function new();
      for (int i = 0; i < MAT_N; i++) begin
        coeff[i] = (i % (VEC_N + 1) == 0) ? word_t'(FX_ONE) : word_t'(0);
      end
      mismatches = 0;
    endfunction

    // One row of M*v: exact sum of the four products, floored by the
    // arithmetic shift, then clamped to the signed word range.
    function word_t transform_row(int row, word_t vin[VEC_N], output logic clamped);
      acc_t sum;
      sum = '0;
      for (int c = 0; c < VEC_N; c++) begin
        sum += acc_t'(prod_t'(coeff[row + VEC_N * c]) * prod_t'(vin[c]));
      end
      sum = sum >>> FRAC_BITS;
      clamped = (sum > ROW_MAX) || (sum < ROW_MIN);
      if (sum > ROW_MAX) begin
        return word_t'(ROW_MAX);
      end
      if (sum < ROW_MIN) begin
        return word_t'(ROW_MIN);
      end
      return word_t'(sum);
    endfunction

    // A load updates the matrix copy; a transform queues the vertex it yields.
    function void note_request(xform_req_t rq);
      word_t   vin[VEC_N];
      vertex_t exp_v;
      logic    c0, c1, c2, c3;
      if (rq.mode == MODE_LOAD) begin
        coeff[rq.index] = rq.value;
      end else begin
        vin = '{rq.vx, rq.vy, rq.vz, rq.vw};
        exp_v.x = transform_row(0, vin, c0);
        exp_v.y = transform_row(1, vin, c1);
        exp_v.z = transform_row(2, vin, c2);
        exp_v.w = transform_row(3, vin, c3);
        exp_v.ovf = c0 | c1 | c2 | c3;
        expected_vertices.push_back(exp_v);
      end
    endfunction

    function void compare_word(string name, word_t expected, word_t actual);
      if (actual !== expected) begin
        $error("%s: expected %h, actual %h", name, expected, actual);
        mismatches++;
      end
    endfunction

    // Each result is matched against the oldest outstanding transform.
    function void check_result(vertex_t got);
      vertex_t exp_v;
      if (expected_vertices.size() == 0) begin
        $error("result received with no transform request outstanding");
        mismatches++;
      end else begin
        exp_v = expected_vertices.pop_front();
        compare_word("out_x", exp_v.x, got.x);
        compare_word("out_y", exp_v.y, got.y);
        compare_word("out_z", exp_v.z, got.z);
        compare_word("out_w", exp_v.w, got.w);
        if (got.ovf !== exp_v.ovf) begin
          $error("overflow: expected %b, actual %b", exp_v.ovf, got.ovf);
          mismatches++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_vertices.size();
    endfunction
  endclass

endpackage

// File: sim/matrix_vector_transform_test.sv
`timescale 1ns / 100ps

module matrix_vector_transform_test;
  import mvt_pkg::*;
  import mvt_vertex_sb_pkg::*;

  localparam int    CLK_HALF      = 4;
  localparam int    RESET_CYCLES  = 9;
  localparam int    RANDOM_ITEMS  = 1950;
  localparam int    SETTLE_CYCLES = 16;
  localparam int    IDLE_LIMIT    = 4000;
  localparam word_t WORD_MAX      = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam word_t WORD_MIN      = {1'b1, {(DATA_W - 1){1'b0}}};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        req_taken = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned ready_left = 0;
  int unsigned requests_issued = 0;

  vertex_scoreboard vertex_sb;

  mvt_in_if  req_if ();
  mvt_out_if res_if ();

  matrix_vector_transform u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Mostly small Q16.16 values, with the extremes and full-width noise mixed in.
  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return word_t'($signed($urandom_range(0, 4)) - 2);
      3, 4: return word_t'($urandom);
      default: return word_t'($signed($urandom_range(0, 1 << (FRAC_BITS + 3)))
                              - (1 << (FRAC_BITS + 2)));
    endcase
  endfunction

  // Request builders; the fields that the operation ignores carry noise.
  function automatic xform_req_t load_req(logic [IDX_W-1:0] idx, word_t val);
    xform_req_t rq;
    rq.mode  = MODE_LOAD;
    rq.index = idx;
    rq.value = val;
    rq.vx    = word_t'($urandom);
    rq.vy    = word_t'($urandom);
    rq.vz    = word_t'($urandom);
    rq.vw    = word_t'($urandom);
    return rq;
  endfunction

  function automatic xform_req_t xform_req(word_t x, word_t y, word_t z, word_t w);
    xform_req_t rq;
    rq.mode  = MODE_XFORM;
    rq.index = IDX_W'($urandom);
    rq.value = word_t'($urandom);
    rq.vx    = x;
    rq.vy    = y;
    rq.vz    = z;
    rq.vw    = w;
    return rq;
  endfunction

  // Sends one request in bursts separated by random gaps, and returns on the
  // falling edge after it was accepted.
  task automatic issue_request(input xform_req_t rq);
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                              : $urandom_range(1, 30);
    end
    burst_left--;
    req_if.mode       <= rq.mode;
    req_if.elem_index <= rq.index;
    req_if.elem_value <= rq.value;
    req_if.vec_x      <= rq.vx;
    req_if.vec_y      <= rq.vy;
    req_if.vec_z      <= rq.vz;
    req_if.vec_w      <= rq.vw;
    req_if.valid      <= 1'b1;
    do @(negedge clk_i); while (!req_taken);
    requests_issued++;
  endtask

  // Holds the request side off until every outstanding vertex has returned.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (vertex_sb.pending() != 0);
  endtask

  // Both handshakes are sampled on the rising edge; the watchdog counts
  // cycles in which neither side moves a request.
  always @(posedge clk_i) begin : monitor
    vertex_t got;
    req_taken <= req_if.valid && req_if.ready;
    if (req_if.valid && req_if.ready) begin
      vertex_sb.note_request('{req_if.mode, req_if.elem_index, req_if.elem_value,
                               req_if.vec_x, req_if.vec_y, req_if.vec_z, req_if.vec_w});
    end
    if (res_if.valid && res_if.ready) begin
      got.x   = res_if.out_x;
      got.y   = res_if.out_y;
      got.z   = res_if.out_z;
      got.w   = res_if.out_w;
      got.ovf = res_if.overflow;
      vertex_sb.check_result(got);
    end
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("matrix_vector_transform: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The result side alternates ready and stalled stretches of random length,
  // with the occasional long stretch of no back-pressure at all.
  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      if (res_if.ready) begin
        res_if.ready <= 1'b0;
        ready_left   <= $urandom_range(1, 10);
      end else begin
        res_if.ready <= 1'b1;
        ready_left   <= ($urandom_range(0, 5) == 0) ? $urandom_range(80, 200)
                                                   : $urandom_range(1, 20);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  initial begin
    xform_req_t  rq;
    int unsigned random_start;
    vertex_sb = new();
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.mode       = MODE_LOAD;
    req_if.elem_index = '0;
    req_if.elem_value = '0;
    req_if.vec_x      = '0;
    req_if.vec_y      = '0;
    req_if.vec_z      = '0;
    req_if.vec_w      = '0;
    res_if.ready      = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The identity matrix passes the extremes through unchanged.
    issue_request(xform_req(WORD_MAX, WORD_MIN, word_t'(0), word_t'(-1)));
    // Row 0 full of the largest value saturates upwards and downwards.
    for (int i = 0; i < VEC_N; i++) begin
      issue_request(load_req(IDX_W'(VEC_N * i), WORD_MAX));
    end
    issue_request(xform_req(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
    issue_request(xform_req(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
    // The smallest coefficient times minus one floors to minus one, and the
    // load is seen by the transform directly behind it.
    issue_request(load_req(IDX_W'(1), word_t'(1)));
    issue_request(xform_req(word_t'(-1), word_t'(0), word_t'(0), word_t'(0)));
    // Most negative times most negative in the last position.
    issue_request(load_req(IDX_W'(MAT_N - 1), WORD_MIN));
    issue_request(xform_req(word_t'(0), word_t'(0), word_t'(0), WORD_MIN));
    issue_request(load_req(IDX_W'(0), WORD_MIN));
    issue_request(xform_req(WORD_MIN, WORD_MAX, word_t'(FX_ONE), WORD_MIN));
    wait_drained();
    // Matrix-matrix product: the columns of twice the identity, one by one.
    for (int c = 0; c < VEC_N; c++) begin
      issue_request(xform_req(word_t'((c == 0) ? 2 * FX_ONE : 0),
                              word_t'((c == 1) ? 2 * FX_ONE : 0),
                              word_t'((c == 2) ? 2 * FX_ONE : 0),
                              word_t'((c == 3) ? 2 * FX_ONE : 0)));
    end
    wait_drained();

    // Random part: vertex strips against matrices that are reloaded now and
    // then, with single loads, noise requests and drain pauses mixed in.
    random_start = requests_issued;
    while (requests_issued - random_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 15))
        0: begin
          for (int i = 0; i < MAT_N; i++) begin
            issue_request(load_req(IDX_W'(i), rand_word()));
          end
        end
        1: issue_request(load_req(IDX_W'($urandom_range(0, MAT_N - 1)), rand_word()));
        2: begin
          rq.mode  = 1'($urandom_range(0, 1));
          rq.index = IDX_W'($urandom);
          rq.value = word_t'($urandom);
          rq.vx    = word_t'($urandom);
          rq.vy    = word_t'($urandom);
          rq.vz    = word_t'($urandom);
          rq.vw    = word_t'($urandom);
          issue_request(rq);
        end
        3: begin
          wait_drained();
          issue_request(xform_req(rand_word(), rand_word(), rand_word(), rand_word()));
        end
        default: begin
          repeat ($urandom_range(1, 8)) begin
            issue_request(xform_req(rand_word(), rand_word(), rand_word(), rand_word()));
          end
        end
      endcase
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (vertex_sb.mismatches == 0 && vertex_sb.pending() == 0) begin
      $display("matrix_vector_transform: match");
    end else begin
      $display("matrix_vector_transform: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/mvt_pkg.sv
design/mvt_in_if.sv
design/mvt_out_if.sv
design/mvt_mac.sv
design/mvt_reduce.sv
design/matrix_vector_transform.sv
sim/mvt_vertex_sb_pkg.sv
sim/matrix_vector_transform_test.sv
